>>> sv/ctcp_pkg.sv
// ----------------------------------------------------------------------------
// Contrast text color picker package
// Shared types, constants and helpers of the contrast text color picker.
// ----------------------------------------------------------------------------
package ctcp_pkg;

	localparam int LIN_FRAC_BITS_DEF = 16;
	localparam int COLOR_W           = 24;
	localparam int CFG_IDX_W         = 8;

	// Luminance weights in Q0.16; they sum to one.
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;
	localparam logic [15:0] W_ROUND = 16'd32768;

	localparam logic [COLOR_W-1:0] DARK_RESET  = 24'h000000;
	localparam logic [COLOR_W-1:0] LIGHT_RESET = 24'hFFFFFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DARK_TEXT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_TEXT = 8'd1;

	typedef struct packed {
		logic               is_tram_badge;
		logic [COLOR_W-1:0] accent_color;
	} ctcp_in_t;

	typedef struct packed {
		logic [15:0] text_color_565;
		logic        picked_light;
	} ctcp_out_t;

	// Stage enables of the luminance pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} ctcp_lum_en_t;

	// Stage enables of the contrast compare pipeline.
	typedef struct packed {
		logic s4;
		logic s5;
	} ctcp_cmp_en_t;

	function automatic logic [15:0] pack565(input logic [COLOR_W-1:0] rgb);
		return {rgb[23:19], rgb[15:10], rgb[7:3]};
	endfunction

endpackage

>>> sv/ctcp_lum.sv
// ----------------------------------------------------------------------------
// Relative luminance pipeline
// Linearizes the three sRGB channels of one color through a constant table,
// weights them and sums them to a Q0.F luminance over three stages.
// ----------------------------------------------------------------------------
module ctcp_lum #(
	parameter int LIN_FRAC_BITS = ctcp_pkg::LIN_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  ctcp_pkg::ctcp_lum_en_t       en,
	input  logic [ctcp_pkg::COLOR_W-1:0] color,
	output logic [LIN_FRAC_BITS:0]       lum
);
	import ctcp_pkg::*;

	localparam int LinW  = LIN_FRAC_BITS + 1;
	localparam int ProdW = LinW + 16;
	localparam int SumW  = ProdW + 2;

	typedef logic [LinW-1:0] lin_lut_t [256];

	// Linear value of one sRGB code, Q0.F. Above the knee the curve is
	// x^2.4 = x^2 * (x^2)^(1/5), the fifth root found by bisection in Q0.30.
	function automatic lin_lut_t build_lut();
		lin_lut_t        lut;
		longint unsigned num;
		longint unsigned x;
		longint unsigned s;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned p;
		longint unsigned lin30;
		int              c;
		int              k;
		for (c = 0; c < 256; c++) begin
			if (c * 100000 <= 3928 * 255) begin
				num = (longint'(c) * 100) << LIN_FRAC_BITS;
				lut[c] = LinW'((num + 164730) / 329460);
			end else begin
				x  = (longint'(1000 * c + 14025) << 30) / 269025;
				s  = (x * x) >> 30;
				lo = 0;
				hi = 64'd1 << 30;
				while (lo < hi) begin
					mid = lo + (hi - lo + 1) / 2;
					p = mid;
					for (k = 0; k < 4; k++) begin
						p = (p * mid) >> 30;
					end
					if (p <= s) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				lin30 = (s * lo) >> 30;
				lut[c] = LinW'((lin30 + (64'd1 << (29 - LIN_FRAC_BITS)))
				               >> (30 - LIN_FRAC_BITS));
			end
		end
		return lut;
	endfunction

	localparam lin_lut_t LinLut = build_lut();

	logic [LinW-1:0]  lin_r_s1, lin_g_s1, lin_b_s1;
	logic [ProdW-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic [LinW-1:0]  lum_s3;
	logic [SumW-1:0]  sum;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			lin_r_s1 <= LinLut[color[23:16]];
			lin_g_s1 <= LinLut[color[15:8]];
			lin_b_s1 <= LinLut[color[7:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_r_s2 <= ProdW'(W_RED) * ProdW'(lin_r_s1);
			prod_g_s2 <= ProdW'(W_GREEN) * ProdW'(lin_g_s1);
			prod_b_s2 <= ProdW'(W_BLUE) * ProdW'(lin_b_s1);
		end
	end

	always_comb begin
		sum = SumW'(prod_r_s2) + SumW'(prod_g_s2) + SumW'(prod_b_s2) + SumW'(W_ROUND);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			lum_s3 <= sum[16 +: LinW];
		end
	end

	assign lum = lum_s3;

endmodule

>>> sv/ctcp_cmp.sv
// ----------------------------------------------------------------------------
// Contrast compare pipeline
// Orders each candidate's luminance against the background, adds the flare
// offset and forms the two cross products of the contrast ratios.
// ----------------------------------------------------------------------------
module ctcp_cmp #(
	parameter int LIN_FRAC_BITS = ctcp_pkg::LIN_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  ctcp_pkg::ctcp_cmp_en_t     en,
	input  logic [LIN_FRAC_BITS:0]     lum_bg,
	input  logic [LIN_FRAC_BITS:0]     lum_dark,
	input  logic [LIN_FRAC_BITS:0]     lum_light,
	output logic [2*LIN_FRAC_BITS+1:0] cross_dark,
	output logic [2*LIN_FRAC_BITS+1:0] cross_light
);
	import ctcp_pkg::*;

	localparam int LinW = LIN_FRAC_BITS + 1;
	localparam int PW   = 2 * LinW;
	localparam logic [LinW-1:0] Offset = LinW'(((1 << LIN_FRAC_BITS) + 10) / 20);

	logic [LinW-1:0] max_d, min_d, max_l, min_l;
	logic [LinW-1:0] max_d_s4, min_d_s4, max_l_s4, min_l_s4;
	logic [PW-1:0]   cross_dark_s5, cross_light_s5;

	always_comb begin
		max_d = (lum_bg > lum_dark) ? lum_bg : lum_dark;
		min_d = (lum_bg > lum_dark) ? lum_dark : lum_bg;
		max_l = (lum_bg > lum_light) ? lum_bg : lum_light;
		min_l = (lum_bg > lum_light) ? lum_light : lum_bg;
	end

	// Luminance is at most one, so the offset sum still fits in LinW bits.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			max_d_s4 <= max_d + Offset;
			min_d_s4 <= min_d + Offset;
			max_l_s4 <= max_l + Offset;
			min_l_s4 <= min_l + Offset;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			cross_dark_s5  <= PW'(max_d_s4) * PW'(min_l_s4);
			cross_light_s5 <= PW'(max_l_s4) * PW'(min_d_s4);
		end
	end

	assign cross_dark  = cross_dark_s5;
	assign cross_light = cross_light_s5;

endmodule

>>> sv/contrast_text_color_picker.sv
// ----------------------------------------------------------------------------
// Contrast text color picker
// Picks the dark or light text color with the higher WCAG contrast against
// a badge background and returns it as RGB565.
// ----------------------------------------------------------------------------
// Usage: a request transfer carries an accent color and a tram-badge flag.
// For a tram badge the background is the light text color, otherwise the
// accent color. Every request gives exactly one response transfer holding
// the chosen text color in RGB565 and a flag that is set when light won.
// Equal contrast goes to the dark color.
// The configuration channel writes the dark (index 0) and light (index 1)
// text colors; it is always ready, and other indexes are dropped. Write it
// only while no request is in flight.
// The block is a six-stage pipeline: three stages of luminance (table,
// weighting, sum), two of contrast compare (offset, cross products) and the
// response register. One transfer is taken every cycle unless req_stall is
// set. Reset empties the pipeline and restores the register defaults.
// When the receiver stalls, the response holds, and the stages behind it
// keep filling empty slots until the pipeline is full; only then does the
// request side stall.
// ----------------------------------------------------------------------------
module contrast_text_color_picker #(
	parameter int LIN_FRAC_BITS = ctcp_pkg::LIN_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  ctcp_pkg::ctcp_in_t             req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output ctcp_pkg::ctcp_out_t            rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ctcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctcp_pkg::COLOR_W-1:0]   cfg_data
);
	import ctcp_pkg::*;

	localparam int LinW = LIN_FRAC_BITS + 1;

	logic [COLOR_W-1:0] dark_q, light_q;
	logic [COLOR_W-1:0] bg_color;
	logic [LinW-1:0]    lum_bg, lum_dark, lum_light;
	logic [2*LinW-1:0]  cross_dark, cross_light;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic               en1, en2, en3, en4, en5, en6;
	ctcp_lum_en_t       lum_en;
	ctcp_cmp_en_t       cmp_en;
	ctcp_out_t          rsp_s6;

	// The configuration registers are always ready; unknown indexes fall
	// through and leave both colors as they are.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= DARK_RESET;
			light_q <= LIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DARK_TEXT:  dark_q  <= cfg_data;
				REG_LIGHT_TEXT: light_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it moves, so
	// bubbles are squeezed out while the response is stalled.
	always_comb begin
		en6 = !vld_s6 || !rsp_stall;
		en5 = !vld_s5 || en6;
		en4 = !vld_s4 || en5;
		en3 = !vld_s3 || en4;
		en2 = !vld_s2 || en3;
		en1 = !vld_s1 || en2;
	end

	assign req_stall = !en1;
	assign lum_en    = '{s1: en1, s2: en2, s3: en3};
	assign cmp_en    = '{s4: en4, s5: en5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= req_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
			if (en4) begin
				vld_s4 <= vld_s3;
			end
			if (en5) begin
				vld_s5 <= vld_s4;
			end
			if (en6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	assign bg_color = req.is_tram_badge ? light_q : req.accent_color;

	// The candidate luminances run through the same pipeline as the
	// background, so every stage sees the three values side by side.
	ctcp_lum #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_lum_bg (
		.clk   (clk),
		.en    (lum_en),
		.color (bg_color),
		.lum   (lum_bg)
	);

	ctcp_lum #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_lum_dark (
		.clk   (clk),
		.en    (lum_en),
		.color (dark_q),
		.lum   (lum_dark)
	);

	ctcp_lum #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_lum_light (
		.clk   (clk),
		.en    (lum_en),
		.color (light_q),
		.lum   (lum_light)
	);

	ctcp_cmp #(.LIN_FRAC_BITS(LIN_FRAC_BITS)) u_cmp (
		.clk         (clk),
		.en          (cmp_en),
		.lum_bg      (lum_bg),
		.lum_dark    (lum_dark),
		.lum_light   (lum_light),
		.cross_dark  (cross_dark),
		.cross_light (cross_light)
	);

	// Dark wins when its contrast ratio is at least that of light. The user
	// keeps the colors stable in flight, unenforced by the block; read here.
	always_ff @(posedge clk) begin
		if (en6) begin
			rsp_s6.picked_light   <= cross_dark < cross_light;
			rsp_s6.text_color_565 <= (cross_dark >= cross_light) ? pack565(dark_q)
			                                                     : pack565(light_q);
		end
	end

	assign rsp_valid = vld_s6;
	assign rsp       = rsp_s6;

endmodule

>>> sv/ctcp_checker.sv
// ----------------------------------------------------------------------------
// Contrast text color picker checker
// Port-level assertions on flow and latency, bound to the top level.
// ----------------------------------------------------------------------------
module ctcp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input ctcp_pkg::ctcp_out_t rsp
);

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// With no response waiting the pipeline has room.
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

	// A free receiver lets every stage move.
	a_flow_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("request stalled while the receiver takes data");

	// An accepted request passes stages s1 to s6 and reaches the output when
	// the receiver does not stall meanwhile.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
		##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
		else $error("response missing after pipeline latency");

endmodule

bind contrast_text_color_picker ctcp_checker u_ctcp_checker (.*);
